FILE: hw/rtl/vcn_pkg.sv
// Package for the vector clock node: item types, kind codes, register indexes, limits.
`timescale 1ns / 1ps
package vcn_pkg;

    localparam int DEF_NUM_NODES = 8;
    localparam int MAX_OUT       = 8;
    localparam int CNT_W         = 32;
    localparam int IDX_W         = 3;
    localparam int MASK_W        = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [2:0] KIND_INTERNAL   = 3'd0;
    localparam logic [2:0] KIND_SEND       = 3'd1;
    localparam logic [2:0] KIND_SEND_MARK  = 3'd2;
    localparam logic [2:0] KIND_RX_ENTRY   = 3'd3;
    localparam logic [2:0] KIND_RX_MARK    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_MASK = 1'b1;

    typedef struct packed {
        logic [2:0]       kind;
        logic [IDX_W-1:0] entry_index;
        logic [CNT_W-1:0] entry_value;
        logic             last_entry;
        logic [IDX_W-1:0] src_node;
    } t_vcn_in;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic [CNT_W-1:0] out_value;
        logic             out_last;
        logic [CNT_W-1:0] message_number;
        logic             is_marker;
        logic             all_markers_done;
    } t_vcn_out;

endpackage

FILE: hw/rtl/vector_clock_node.sv
// Vector clock node: clock RAM, shared max/increment unit and its sequencer.
//
// Input channel (i_in_valid / o_in_ready, payload i_in) takes one event item.
// Output channel (o_out_valid / i_out_ready, payload o_out) gives result items.
// Config port (i_cfg_we, i_cfg_idx, i_cfg_data): index 0 node_id, 1 marker_mask;
// write only while the block is idle.
// All clock entries sit in one RAM with a single read and a single write port;
// every access goes through it, one entry at a time, and the one compare/increment
// unit computes each new value. o_in_ready is high only while the sequencer idles.
// Steps per item: an internal event increments the own entry; a received entry
//   writes the maximum into its slot and, if last, then increments the own entry
//   (dropped once stopped); a receive marker gives one status result; a send
//   first increments the own entry; each send gives min(NUM_NODES, 8) entries.
// Results are held in an output register; while the receiver stalls the sequencer
// waits on the next entry, and a finished item's last result may still wait while
// the next input item is taken.
// Reset (synchronous, active low) clears the clock, the message count, the
// marker mask state and both config registers; the clock RAM is marked empty at
// once by per-entry valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
module vector_clock_node
    import vcn_pkg::*;
#(
    parameter int NUM_NODES = DEF_NUM_NODES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_vcn_in               i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_vcn_out              o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = (NUM_NODES < MAX_OUT) ? NUM_NODES : MAX_OUT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUMP_RD,
        S_BUMP_WR,
        S_MAX_RD,
        S_MAX_WR,
        S_EMIT_RD,
        S_EMIT_LD,
        S_STAT
    } t_state;

    t_state            r_state;
    t_vcn_in           r_in;
    t_vcn_out          r_out;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_node_id;
    logic [MASK_W-1:0] r_marker_mask;
    logic [MASK_W-1:0] r_seen;
    logic              r_stopped;
    logic [CNT_W-1:0]  r_sent;
    logic [CNT_W-1:0]  r_msg;
    logic              r_mark;
    logic              r_emit;
    logic [AW-1:0]     r_cnt;
    logic [DEPTH-1:0]  r_valid;
    logic              r_rd_vld;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;
    logic [CNT_W-1:0]  rd_val;
    logic [CNT_W-1:0]  unit_res;
    logic              own_ok;
    logic              idx_ok;
    logic              in_acc;
    logic [MASK_W-1:0] n_seen;
    logic [CNT_W-1:0]  n_sent;

    assign in_acc = i_in_valid && o_in_ready;
    assign own_ok = int'(r_node_id) < DEPTH;
    assign idx_ok = int'(i_in.entry_index) < DEPTH;
    assign rd_val = r_rd_vld ? ram_rdata : '0;
    assign n_seen = r_seen | (MASK_W'(1) << i_in.src_node);
    assign n_sent = (r_sent == CNT_MAX) ? r_sent : r_sent + CNT_W'(1);

    // shared unit: merge by maximum or saturating increment
    always_comb begin
        if (r_state == S_MAX_WR) begin
            unit_res = (r_in.entry_value > rd_val) ? r_in.entry_value : rd_val;
        end else begin
            unit_res = (rd_val == CNT_MAX) ? rd_val : rd_val + CNT_W'(1);
        end
    end

    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_cnt;
        ram_we    = 1'b0;
        ram_waddr = r_node_id[AW-1:0];
        case (r_state)
            S_BUMP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_node_id[AW-1:0];
            end
            S_MAX_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_in.entry_index[AW-1:0];
            end
            S_EMIT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_cnt;
            end
            S_BUMP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_node_id[AW-1:0];
            end
            S_MAX_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_in.entry_index[AW-1:0];
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    vcn_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_clock_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (unit_res),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_node_id     <= '0;
            r_marker_mask <= '0;
            r_seen        <= '0;
            r_stopped     <= 1'b0;
            r_sent        <= '0;
            r_mark        <= 1'b0;
            r_emit        <= 1'b0;
            r_cnt         <= '0;
            r_valid       <= '0;
            r_rd_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NODE_ID:     r_node_id     <= i_cfg_data[IDX_W-1:0];
                    CFG_MARKER_MASK: r_marker_mask <= i_cfg_data[MASK_W-1:0];
                    default:         r_node_id     <= r_node_id;
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (ram_re) begin
                r_rd_vld <= r_valid[ram_raddr];
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_in   <= i_in;
                        r_cnt  <= '0;
                        r_emit <= 1'b0;
                        case (i_in.kind)
                            KIND_INTERNAL: begin
                                r_state <= own_ok ? S_BUMP_RD : S_IDLE;
                            end
                            KIND_SEND: begin
                                r_sent  <= n_sent;
                                r_msg   <= n_sent;
                                r_mark  <= 1'b0;
                                r_emit  <= 1'b1;
                                r_state <= own_ok ? S_BUMP_RD : S_EMIT_RD;
                            end
                            KIND_SEND_MARK: begin
                                r_msg   <= '0;
                                r_mark  <= 1'b1;
                                r_state <= S_EMIT_RD;
                            end
                            KIND_RX_ENTRY: begin
                                if (r_stopped) begin
                                    r_state <= S_IDLE;
                                end else if (idx_ok) begin
                                    r_state <= S_MAX_RD;
                                end else if (i_in.last_entry && own_ok) begin
                                    r_state <= S_BUMP_RD;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                            KIND_RX_MARK: begin
                                if (!r_stopped) begin
                                    r_seen    <= n_seen;
                                    r_stopped <= (n_seen & r_marker_mask) == r_marker_mask;
                                end
                                r_state <= S_STAT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_BUMP_RD: begin
                    r_state <= S_BUMP_WR;
                end
                S_BUMP_WR: begin
                    r_state <= r_emit ? S_EMIT_RD : S_IDLE;
                end
                S_MAX_RD: begin
                    r_state <= S_MAX_WR;
                end
                S_MAX_WR: begin
                    r_state <= (r_in.last_entry && own_ok) ? S_BUMP_RD : S_IDLE;
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid            <= 1'b1;
                        r_out.out_index        <= IDX_W'(r_cnt);
                        r_out.out_value        <= rd_val;
                        r_out.out_last         <= (r_cnt == AW'(DEPTH - 1));
                        r_out.message_number   <= r_msg;
                        r_out.is_marker        <= r_mark;
                        r_out.all_markers_done <= r_stopped;
                        if (r_cnt == AW'(DEPTH - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + AW'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                S_STAT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid            <= 1'b1;
                        r_out.out_index        <= '0;
                        r_out.out_value        <= '0;
                        r_out.out_last         <= 1'b0;
                        r_out.message_number   <= '0;
                        r_out.is_marker        <= 1'b0;
                        r_out.all_markers_done <= r_stopped;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: hw/rtl/vcn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vcn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/vcn_checker.sv
// Port-level checker for the vector clock node, bound to the top level.
`timescale 1ns / 1ps
module vcn_checker
    import vcn_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_vcn_in  i_in,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_vcn_out o_out
);

    // a stalled result item is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result item valid after reset");

    a_marker_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.is_marker |-> o_out.message_number == '0)
        else $error("marker vector carries a message number");

    // a send or send-marker item keeps the block busy once it is taken
    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_in.kind == KIND_SEND || i_in.kind == KIND_SEND_MARK)
        |=> !o_in_ready)
        else $error("block ready right after a send item");

endmodule

bind vector_clock_node vcn_checker u_vcn_checker (.*);

FILE: tb/sv/tb_top.sv
// Testbench for the vector clock node: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
    import vcn_pkg::*;

    localparam int NODES = (DEF_NUM_NODES < MAX_OUT) ? DEF_NUM_NODES : MAX_OUT;

    class clock_shadow;
        logic [CNT_W-1:0]  vec [DEF_NUM_NODES];
        logic [CNT_W-1:0]  msgs_sent;
        logic [MASK_W-1:0] seen;
        logic [MASK_W-1:0] need;
        logic              stopped;
        logic [IDX_W-1:0]  own;
        t_vcn_out          due_out [$];
        int                errors;

        function new();
            foreach (vec[i]) vec[i] = '0;
            msgs_sent = '0;
            seen      = '0;
            need      = '0;
            stopped   = 1'b0;
            own       = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_NODE_ID:     own = d[IDX_W-1:0];
                CFG_MARKER_MASK: need = d[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CNT_W-1:0] sat_up(logic [CNT_W-1:0] x);
            return (x == CNT_MAX) ? x : x + 1'b1;
        endfunction

        function void bump_own();
            if (int'(own) < DEF_NUM_NODES) vec[own] = sat_up(vec[own]);
        endfunction

        function void push_vector(logic [CNT_W-1:0] num, logic mark);
            t_vcn_out r;
            for (int i = 0; i < NODES; i++) begin
                r.out_index        = IDX_W'(i);
                r.out_value        = vec[i];
                r.out_last         = (i == NODES - 1);
                r.message_number   = num;
                r.is_marker        = mark;
                r.all_markers_done = stopped;
                due_out = {due_out, r};
            end
        endfunction

        function void take_event(t_vcn_in it);
            t_vcn_out r;
            case (it.kind)
                KIND_INTERNAL: bump_own();
                KIND_SEND: begin
                    bump_own();
                    msgs_sent = sat_up(msgs_sent);
                    push_vector(msgs_sent, 1'b0);
                end
                KIND_SEND_MARK: push_vector('0, 1'b1);
                KIND_RX_ENTRY: begin
                    if (!stopped) begin
                        if (int'(it.entry_index) < DEF_NUM_NODES &&
                            it.entry_value > vec[it.entry_index])
                            vec[it.entry_index] = it.entry_value;
                        if (it.last_entry) bump_own();
                    end
                end
                KIND_RX_MARK: begin
                    if (!stopped) begin
                        seen = seen | (MASK_W'(1) << it.src_node);
                        if ((seen & need) == need) stopped = 1'b1;
                    end
                    r = '0;
                    r.all_markers_done = stopped;
                    due_out = {due_out, r};
                end
                default: ;
            endcase
        endfunction

        function void cmp(string name, logic [CNT_W-1:0] e, logic [CNT_W-1:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, e, a);
            end
        endfunction

        function void match_out(t_vcn_out got);
            t_vcn_out e;
            if (due_out.size() == 0) begin
                errors++;
                $display("%0t: result item expected none actual %h", $time, got);
                return;
            end
            e = due_out.pop_front();
            cmp("out_index", CNT_W'(e.out_index), CNT_W'(got.out_index));
            cmp("out_value", e.out_value, got.out_value);
            cmp("out_last", CNT_W'(e.out_last), CNT_W'(got.out_last));
            cmp("message_number", e.message_number, got.message_number);
            cmp("is_marker", CNT_W'(e.is_marker), CNT_W'(got.is_marker));
            cmp("all_markers_done", CNT_W'(e.all_markers_done),
                CNT_W'(got.all_markers_done));
        endfunction

        function int pending();
            return due_out.size();
        endfunction

        function logic [CNT_W-1:0] peek(logic [IDX_W-1:0] idx);
            return vec[idx];
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_vcn_in               i_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_vcn_out              o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bit          idle_on;
    clock_shadow shadow;

    vector_clock_node uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("vector_clock_node regression: fail");
        $finish;
    end

    // receiver stalls
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 15) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) shadow.match_out(o_out);
            if (i_in_valid && o_in_ready) shadow.take_event(i_in);
        end
    end

    function automatic t_vcn_in rand_item();
        t_vcn_in it;
        it.kind        = 3'($urandom_range(0, 7));
        it.entry_index = IDX_W'($urandom_range(0, 7));
        it.entry_value = $urandom;
        it.last_entry  = 1'($urandom_range(0, 1));
        it.src_node    = IDX_W'($urandom_range(0, 7));
        return it;
    endfunction

    function automatic t_vcn_in mk(logic [2:0] kind, logic [IDX_W-1:0] idx,
                                   logic [CNT_W-1:0] val, logic last,
                                   logic [IDX_W-1:0] sender);
        t_vcn_in it;
        it.kind        = kind;
        it.entry_index = idx;
        it.entry_value = val;
        it.last_entry  = last;
        it.src_node    = sender;
        return it;
    endfunction

    function automatic logic [CNT_W-1:0] entry_guess(logic [IDX_W-1:0] idx);
        int sel;
        sel = $urandom_range(0, 31);
        if (sel == 0) return CNT_MAX;
        if (sel == 1) return $urandom;
        if (sel < 4) return '0;
        if (sel < 8) return CNT_W'($urandom_range(0, 255));
        return shadow.peek(idx) + CNT_W'($urandom_range(0, 6)) - CNT_W'(3);
    endfunction

    // returns at the accepting edge
    task automatic push_item(input t_vcn_in it);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // wait for all results, then let no-result items finish inside the block
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (shadow.pending() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // called at a falling edge
    task automatic set_regs(input logic [IDX_W-1:0] nid, input logic [MASK_W-1:0] mask);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_NODE_ID;
        i_cfg_data <= CFG_DATA_W'(nid);
        shadow.write_reg(CFG_NODE_ID, CFG_DATA_W'(nid));
        @(negedge i_clk);
        i_cfg_idx  <= CFG_MARKER_MASK;
        i_cfg_data <= CFG_DATA_W'(mask);
        shadow.write_reg(CFG_MARKER_MASK, CFG_DATA_W'(mask));
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic directed();
        logic [CNT_W-1:0] vals [NODES];
        vals = '{32'd3, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'd0, 32'd7, 32'd1, 32'd2};
        push_item(mk(KIND_INTERNAL, 3'd0, '0, 1'b0, 3'd0));
        push_item(mk(KIND_SEND, 3'd0, '0, 1'b0, 3'd0));
        push_item(mk(KIND_SEND_MARK, 3'd0, '0, 1'b0, 3'd0));
        for (int i = 0; i < NODES; i++)
            push_item(mk(KIND_RX_ENTRY, IDX_W'(i), vals[i], i == NODES - 1, 3'd0));
        push_item(mk(KIND_SEND, 3'd7, '1, 1'b1, 3'd7));
        // own entry driven to saturation
        push_item(mk(KIND_RX_ENTRY, 3'd0, CNT_MAX, 1'b1, 3'd0));
        push_item(mk(KIND_INTERNAL, 3'd0, '0, 1'b0, 3'd0));
        push_item(mk(KIND_SEND, 3'd0, '0, 1'b0, 3'd0));
        push_item(mk(KIND_RX_ENTRY, 3'd2, 32'd1, 1'b0, 3'd0));
        push_item(mk(KIND_RX_MARK, 3'd0, '0, 1'b0, 3'd0));
        push_item(mk(KIND_RX_MARK, 3'd7, '1, 1'b1, 3'd6));
        for (int k = int'(KIND_RX_MARK) + 1; k < 8; k++) begin
            push_item(mk(3'(k), IDX_W'($urandom_range(0, 7)), $urandom,
                         1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 7))));
        end
        push_item(mk(KIND_SEND_MARK, 3'd5, 32'h1234_5678, 1'b1, 3'd3));
    endtask

    task automatic run_phase(input int quota, input bit any_sender);
        int      fed;
        int      pick;
        int      start;
        int      len;
        bit      paused;
        t_vcn_in it;
        fed    = 0;
        paused = 1'b0;
        while (fed < quota) begin
            if (!paused && fed >= quota / 2) begin
                settle();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            it   = rand_item();
            if (pick < 40) begin
                start = $urandom_range(0, NODES - 1);
                for (int k = 0; k < NODES; k++) begin
                    it = rand_item();
                    it.kind        = KIND_RX_ENTRY;
                    it.entry_index = IDX_W'((start + k) % NODES);
                    it.entry_value = entry_guess(it.entry_index);
                    it.last_entry  = (k == NODES - 1);
                    push_item(it);
                end
                fed += NODES;
            end else if (pick >= 97) begin
                // message cut short, no final entry
                len = $urandom_range(1, NODES - 1);
                for (int k = 0; k < len; k++) begin
                    it = rand_item();
                    it.kind        = KIND_RX_ENTRY;
                    it.entry_index = IDX_W'(k);
                    it.entry_value = entry_guess(it.entry_index);
                    it.last_entry  = 1'b0;
                    push_item(it);
                end
                fed += len;
            end else if (pick >= 94) begin
                it.kind = 3'($urandom_range(int'(KIND_RX_MARK) + 1, 7));
                push_item(it);
                fed++;
            end else begin
                if (pick < 55) it.kind = KIND_INTERNAL;
                else if (pick < 70) it.kind = KIND_SEND;
                else if (pick < 78) it.kind = KIND_SEND_MARK;
                else if (pick < 86) begin
                    it.kind     = KIND_RX_MARK;
                    it.src_node = IDX_W'(any_sender ? $urandom_range(0, 7)
                                                    : $urandom_range(0, 6));
                end else begin
                    it.kind        = KIND_RX_ENTRY;
                    it.entry_value = entry_guess(it.entry_index);
                end
                push_item(it);
                fed++;
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        idle_on    = 1'b1;
        shadow     = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_regs(3'd0, 8'hFF);
        directed();

        settle();
        set_regs(IDX_W'($urandom_range(1, 6)), 8'h80 | MASK_W'($urandom_range(0, 127)));
        run_phase(70, 1'b0);

        settle();
        set_regs(3'd0, 8'hFF);
        run_phase(70, 1'b0);

        settle();
        set_regs(IDX_W'($urandom_range(0, 7)), 8'h80 | MASK_W'($urandom_range(0, 127)));
        run_phase(60, 1'b0);

        // no idling; empty mask, so the first marker stops receiving
        settle();
        idle_on = 1'b0;
        set_regs(3'd7, 8'h00);
        run_phase(70, 1'b1);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("vector_clock_node regression: pass");
        else
            $display("vector_clock_node regression: fail");
        $finish;
    end

endmodule
